@@ src/utilization_frequency_governor_macros.svh @@
// Assertion macros shared by the governor's checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UTILIZATION_FREQUENCY_GOVERNOR_MACROS_SVH
`define UTILIZATION_FREQUENCY_GOVERNOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UFG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ufg_pkg.sv @@
// Package for the utilization frequency governor: widths, word layouts,
// register indexes, reset values, sequencer states and shared structs. No dependencies.
package ufg_pkg;

    // field widths
    localparam int FREQ_W     = 19;
    localparam int UTIL_W     = 7;
    localparam int REP_W      = 8;
    localparam int TEMP_W     = 12;
    localparam int TIME_W     = 64;
    localparam int QUIET_W    = 27;
    localparam int STEP_W     = 17;
    localparam int VREQ_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // stream word layouts
    localparam int IN_REP_LSB    = 0;
    localparam int IN_TEMP_LSB   = IN_REP_LSB + REP_W;
    localparam int IN_NOW_LSB    = IN_TEMP_LSB + TEMP_W;
    localparam int IN_RUN_LSB    = IN_NOW_LSB + TIME_W;
    localparam int IN_BITS       = IN_RUN_LSB + FREQ_W;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_GOAL_LSB  = 0;
    localparam int OUT_UTIL_LSB  = OUT_GOAL_LSB + FREQ_W;
    localparam int OUT_VREQ_LSB  = OUT_UTIL_LSB + UTIL_W;
    localparam int OUT_RAMP_LSB  = OUT_VREQ_LSB + VREQ_W;
    localparam int OUT_BITS      = OUT_RAMP_LSB + 1;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // shared divider
    localparam int DIV_W     = 26;
    localparam int DIVR_W    = 19;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int PCT_W     = DIV_W + 1;

    // arithmetic constants
    localparam logic [UTIL_W-1:0]        UTIL_MAX    = 7'd100;
    localparam logic [UTIL_W-1:0]        UTIL_IDLE   = 7'd20;
    localparam logic [DIVR_W-1:0]        PCT_SCALE   = 19'd100;
    localparam logic [DIVR_W-1:0]        TEMP_SCALE  = 19'd20;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 12'sd320;
    localparam logic signed [TEMP_W-1:0] TEMP_COOL   = 12'sd480;
    localparam int                       HYST_PCT    = 5;

    // voltage request codes
    localparam logic [VREQ_W-1:0] VREQ_NONE = 2'd0;
    localparam logic [VREQ_W-1:0] VREQ_MID  = 2'd1;
    localparam logic [VREQ_W-1:0] VREQ_TOP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_PCT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_VOLT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MID_VOLT   = 3'd7;

    typedef struct packed {
        logic [FREQ_W-1:0]  min_freq;
        logic [FREQ_W-1:0]  max_freq;
        logic [UTIL_W-1:0]  busy_pct;
        logic [QUIET_W-1:0] quiet_time;
        logic [QUIET_W-1:0] cooldown;
        logic [STEP_W-1:0]  decay_step;
        logic [FREQ_W-1:0]  top_volt;
        logic [FREQ_W-1:0]  mid_volt;
    } ufg_cfg_t;

    localparam ufg_cfg_t CFG_RESET = '{
        min_freq:   19'd125000,
        max_freq:   19'd266000,
        busy_pct:   7'd50,
        quiet_time: 27'd2000000,
        cooldown:   27'd500000,
        decay_step: 17'd10000,
        top_volt:   19'd250000,
        mid_volt:   19'd200000
    };

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } ufg_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ufg_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UTIL,
        ST_UTIL_WAIT,
        ST_TGT,
        ST_TGT_DIV,
        ST_TGT_WAIT,
        ST_PCT,
        ST_PCT_DIV,
        ST_PCT_WAIT,
        ST_DECIDE,
        ST_DECAY,
        ST_DONE
    } ufg_state_t;

endpackage

@@ src/ufg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ufg_pkg.
module ufg_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ufg_pkg::ufg_div_req_t   req,
    output ufg_pkg::ufg_div_stat_t  stat,
    output logic [ufg_pkg::DIV_W-1:0] quotient
);
    import ufg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    dvs_reg, dvs_next;
    logic [DIVR_W:0]      rem_sh;
    logic [DIVR_W+1:0]    trial;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        trial     = {1'b0, rem_sh} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // trial subtract; keep the shifted remainder on borrow
            if (trial[DIVR_W+1])
                rem_next = rem_sh[DIVR_W-1:0];
            else
                rem_next = trial[DIVR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ~trial[DIVR_W+1]};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ src/ufg_cfg.sv @@
// Configuration register bank of the governor, written by index.
// Depends on ufg_pkg.
module ufg_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [ufg_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ufg_pkg::CFG_DATA_W-1:0]   wr_data,
    output ufg_pkg::ufg_cfg_t                cfg
);
    import ufg_pkg::*;

    ufg_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_MIN_FREQ:   cfg_next.min_freq   = wr_data[FREQ_W-1:0];
                REG_MAX_FREQ:   cfg_next.max_freq   = wr_data[FREQ_W-1:0];
                REG_BUSY_PCT:   cfg_next.busy_pct   = wr_data[UTIL_W-1:0];
                REG_QUIET_TIME: cfg_next.quiet_time = wr_data[QUIET_W-1:0];
                REG_COOLDOWN:   cfg_next.cooldown   = wr_data[QUIET_W-1:0];
                REG_DECAY_STEP: cfg_next.decay_step = wr_data[STEP_W-1:0];
                REG_TOP_VOLT:   cfg_next.top_volt   = wr_data[FREQ_W-1:0];
                REG_MID_VOLT:   cfg_next.mid_volt   = wr_data[FREQ_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ src/utilization_frequency_governor.sv @@
// Top level of the utilization frequency governor: sequencer, state and stream ports.
// Depends on ufg_pkg, ufg_div and ufg_cfg.
//
// Usage:
//   One input word per governor tick on s_axis_*. tuser carries the report flag; tdata
//   carries the reported utilization, the signed temperature in tenths of a degree,
//   the time in microseconds and the running frequency. One result word per tick
//   leaves on m_axis_*: goal frequency, utilization used, voltage code, ramp request.
//   The cfg_* channel writes the eight registers by index; cfg_ready is always high.
//   Write registers only while no tick is in flight.
// Sequencing:
//   A shared 26-step restoring divider runs up to three times per tick: temperature
//   to percent (only when there is no report and the die is at 32.0 C or above), span
//   scaling, and goal percentage (skipped when max <= min leaves the span zero).
//   s_axis_tready rises with the result, so a new tick is taken only once the last
//   one's result word is in the output register.
// Reset: registers take their defaults, the goal is the default minimum (125000 kHz),
//   both activity and decay time stamps are zero.
// Back-pressure: the next tick runs while the result waits in the output register; a
//   finished tick holds in its last state until that register is free.
module utilization_frequency_governor (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] reported_util, [19:8] temp_tenths, [83:20] now_us,
    // [102:84] running_khz, [103] zero
    input  logic [ufg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] report_present
    input  logic                               s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [18:0] goal_khz, [25:19] util_percent, [27:26] voltage_request,
    // [28] ramp_request, [31:29] zero
    output logic [ufg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ufg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ufg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ufg_pkg::*;

    ufg_cfg_t      cfg;
    ufg_div_req_t  div_req;
    ufg_div_stat_t div_stat;
    logic [DIV_W-1:0] div_quo;

    ufg_state_t state_reg, state_next;

    // control and architectural state
    logic [FREQ_W-1:0]      goal_reg, goal_next;
    logic [TIME_W-1:0]      last_busy_reg, last_busy_next;
    logic [TIME_W-1:0]      last_decay_reg, last_decay_next;
    logic                   out_valid_reg, out_valid_next;

    // per-tick working registers
    logic                   has_reg, has_next;
    logic [REP_W-1:0]       rep_reg, rep_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [FREQ_W-1:0]      run_reg, run_next;
    logic [UTIL_W-1:0]      util_reg, util_next;
    logic [DIV_W-1:0]       prod_reg, prod_next;
    logic [FREQ_W-1:0]      target_reg, target_next;
    logic signed [PCT_W-1:0] pct_reg, pct_next;
    logic                   neg_reg, neg_next;
    logic                   quiet_reg, quiet_next;
    logic                   cool_reg, cool_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // combinational helpers
    logic                   accept;
    logic                   out_free;
    logic [FREQ_W-1:0]      span;
    logic signed [TEMP_W-1:0] temp_sub;
    logic [FREQ_W:0]        goal_diff;
    logic [FREQ_W:0]        goal_mag;
    logic [PCT_W-1:0]       quo_ext;
    logic signed [PCT_W:0]  hyst_diff;
    logic [FREQ_W:0]        decayed;
    logic [TIME_W-1:0]      since_busy;
    logic [TIME_W-1:0]      since_decay;
    logic [VREQ_W-1:0]      vreq;

    ufg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ufg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        // defaults
        state_next      = state_reg;
        goal_next       = goal_reg;
        last_busy_next  = last_busy_reg;
        last_decay_next = last_decay_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        has_next        = has_reg;
        rep_next        = rep_reg;
        temp_next       = temp_reg;
        now_next        = now_reg;
        run_next        = run_reg;
        util_next       = util_reg;
        prod_next       = prod_reg;
        target_next     = target_reg;
        pct_next        = pct_reg;
        neg_next        = neg_reg;
        quiet_next      = quiet_reg;
        cool_next       = cool_reg;
        out_data_next   = out_data_reg;
        div_req         = '0;

        span        = (cfg.max_freq > cfg.min_freq) ? (cfg.max_freq - cfg.min_freq) : '0;
        temp_sub    = temp_reg - TEMP_OFFSET;
        goal_diff   = {1'b0, goal_reg} - {1'b0, cfg.min_freq};
        goal_mag    = goal_diff[FREQ_W] ? (~goal_diff + 1'b1) : goal_diff;
        quo_ext     = {1'b0, div_quo};
        hyst_diff   = $signed({{(PCT_W+1-UTIL_W){1'b0}}, util_reg}) - $signed({pct_reg[PCT_W-1],
                      pct_reg});
        decayed     = {1'b0, goal_reg} - {{(FREQ_W+1-STEP_W){1'b0}}, cfg.decay_step};
        since_busy  = now_reg - last_busy_reg;
        since_decay = now_reg - last_decay_reg;

        if (goal_reg > run_reg)
        begin
            if (goal_reg > cfg.top_volt)
                vreq = VREQ_TOP;
            else if (goal_reg > cfg.mid_volt)
                vreq = VREQ_MID;
            else
                vreq = VREQ_NONE;
        end
        else
            vreq = VREQ_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    has_next  = s_axis_tuser;
                    rep_next  = s_axis_tdata[IN_REP_LSB +: REP_W];
                    temp_next = s_axis_tdata[IN_TEMP_LSB +: TEMP_W];
                    now_next  = s_axis_tdata[IN_NOW_LSB +: TIME_W];
                    run_next  = s_axis_tdata[IN_RUN_LSB +: FREQ_W];
                    // activity uses the unclamped report
                    if (s_axis_tuser &&
                        (s_axis_tdata[IN_REP_LSB +: REP_W] > {1'b0, cfg.busy_pct}))
                        last_busy_next = s_axis_tdata[IN_NOW_LSB +: TIME_W];
                    state_next = ST_UTIL;
                end
            end
            ST_UTIL:
            begin
                if (has_reg)
                begin
                    util_next  = (rep_reg > {1'b0, UTIL_MAX}) ? UTIL_MAX : rep_reg[UTIL_W-1:0];
                    state_next = ST_TGT;
                end
                else if (temp_reg >= TEMP_OFFSET)
                begin
                    // (T - 320) / 20, never above 86 for a 12-bit temperature
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(DIV_W-TEMP_W){1'b0}}, temp_sub};
                    div_req.divisor  = TEMP_SCALE;
                    state_next       = ST_UTIL_WAIT;
                end
                else
                begin
                    util_next  = '0;
                    state_next = ST_TGT;
                end
            end
            ST_UTIL_WAIT:
            begin
                if (div_stat.done)
                begin
                    util_next  = div_quo[UTIL_W-1:0];
                    state_next = ST_TGT;
                end
            end
            ST_TGT:
            begin
                prod_next  = DIV_W'(span) * DIV_W'(util_reg);
                quiet_next = since_busy > {{(TIME_W-QUIET_W){1'b0}}, cfg.quiet_time};
                state_next = ST_TGT_DIV;
            end
            ST_TGT_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = PCT_SCALE;
                state_next       = ST_TGT_WAIT;
            end
            ST_TGT_WAIT:
            begin
                if (div_stat.done)
                begin
                    // quotient never exceeds span, so target stays within max unless max is below min
                    target_next = cfg.min_freq + div_quo[FREQ_W-1:0];
                    state_next  = ST_PCT;
                end
            end
            ST_PCT:
            begin
                neg_next   = goal_diff[FREQ_W];
                prod_next  = DIV_W'(goal_mag[FREQ_W-1:0]) * DIV_W'(PCT_SCALE);
                cool_next  = since_decay >= {{(TIME_W-QUIET_W){1'b0}}, cfg.cooldown};
                state_next = ST_PCT_DIV;
            end
            ST_PCT_DIV:
            begin
                if (span == '0)
                begin
                    pct_next   = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_reg;
                    div_req.divisor  = span;
                    state_next       = ST_PCT_WAIT;
                end
            end
            ST_PCT_WAIT:
            begin
                if (div_stat.done)
                begin
                    // truncation toward zero: divide magnitude, then restore sign
                    pct_next   = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // hysteresis on the signed distance to the goal's own percentage
                if ((target_reg != goal_reg) &&
                    ((hyst_diff > (PCT_W+1)'(HYST_PCT)) || (hyst_diff < -(PCT_W+1)'(HYST_PCT))))
                    goal_next = target_reg;
                state_next = ST_DECAY;
            end
            ST_DECAY:
            begin
                // idle decay: no report, cool, lightly loaded, goal above min, quiet long enough, cooldown expired
                if (!has_reg && (util_reg < UTIL_IDLE) && (temp_reg < TEMP_COOL) &&
                    (goal_reg > cfg.min_freq) && quiet_reg && cool_reg)
                begin
                    if (decayed[FREQ_W] || (decayed[FREQ_W-1:0] < cfg.min_freq))
                        goal_next = cfg.min_freq;
                    else
                        goal_next = decayed[FREQ_W-1:0];
                    last_decay_next = now_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, (goal_reg != run_reg),
                                      vreq, util_reg, goal_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            goal_reg       <= CFG_RESET.min_freq;
            last_busy_reg  <= '0;
            last_decay_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            goal_reg       <= goal_next;
            last_busy_reg  <= last_busy_next;
            last_decay_reg <= last_decay_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        has_reg      <= has_next;
        rep_reg      <= rep_next;
        temp_reg     <= temp_next;
        now_reg      <= now_next;
        run_reg      <= run_next;
        util_reg     <= util_next;
        prod_reg     <= prod_next;
        target_reg   <= target_next;
        pct_reg      <= pct_next;
        neg_reg      <= neg_next;
        quiet_reg    <= quiet_next;
        cool_reg     <= cool_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ src/ufg_checker.sv @@
// Port-level checker for the governor, bound to the top level.
// Depends on ufg_pkg and utilization_frequency_governor_macros.svh.
`include "utilization_frequency_governor_macros.svh"

module ufg_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ufg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ufg_pkg::*;

    // a stalled result word holds
    `UFG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // one tick at a time: busy right after an accept
    `UFG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input accepted while a tick is in progress")

    // utilization estimate is clamped to 100
    `UFG_ASSERT_NOW(a_util_range, m_axis_tvalid,
        m_axis_tdata[OUT_UTIL_LSB +: UTIL_W] <= UTIL_MAX, "utilization above 100")

    // voltage code never reserved
    `UFG_ASSERT_NOW(a_vreq_code, m_axis_tvalid,
        (m_axis_tdata[OUT_VREQ_LSB +: VREQ_W] == VREQ_NONE) ||
        (m_axis_tdata[OUT_VREQ_LSB +: VREQ_W] == VREQ_MID) ||
        (m_axis_tdata[OUT_VREQ_LSB +: VREQ_W] == VREQ_TOP), "reserved voltage code")

endmodule

bind utilization_frequency_governor ufg_checker u_ufg_checker (.*);

@@ verif/tb_utilization_frequency_governor.sv @@
// Self-checking testbench for utilization_frequency_governor: directed and random ticks,
// predicted per tick and compared word by word on the result stream.
// Depends on ufg_pkg and the governor RTL only.
module tb_utilization_frequency_governor;
    timeunit 1ns;
    timeprecision 1ps;

    import ufg_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int REPORT_LIMIT = 10;

    // one governor tick as it enters on s_axis
    typedef struct packed {
        logic              has;
        logic [REP_W-1:0]  rep;
        logic [TEMP_W-1:0] temp;   // two's complement, tenths of a degree
        logic [TIME_W-1:0] now;
        logic [FREQ_W-1:0] run;
    } tick_t;

    // one result word as it leaves on m_axis
    typedef struct packed {
        logic [FREQ_W-1:0] goal;
        logic [UTIL_W-1:0] util;
        logic [VREQ_W-1:0] vreq;
        logic              ramp;
    } verdict_t;

    typedef enum logic {RX_OPEN, RX_CHOPPY} rx_mode_t;

    // DUT ports; every input starts at a known value
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // governor mirror: registers, goal and the two time stamps
    ufg_cfg_t          gov_cfg;
    logic [FREQ_W-1:0] goal_state;
    logic [TIME_W-1:0] busy_stamp;
    logic [TIME_W-1:0] decay_stamp;

    verdict_t tick_verdicts[$];   // results owed by the DUT, oldest first
    int       mismatches = 0;
    int       cycles     = 0;

    // random traffic shaping
    logic [TIME_W-1:0] sim_now_us = '0;
    int                report_share = 50;

    // receiver: hold_request is posted by a test, the receiver process counts it down
    rx_mode_t rx_mode      = RX_CHOPPY;
    int       hold_request = 0;
    int       hold_left    = 0;
    int       rx_run       = 0;
    logic     rx_open      = 1'b1;

    utilization_frequency_governor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Predicts one tick and advances the mirror state.
    function automatic verdict_t govern_tick(tick_t t);
        longint   mn, mx, span, goal, util, target, pct, diff, temp, run, step;
        logic [TIME_W-1:0] since_busy, since_decay;
        verdict_t v;
        mn   = longint'(gov_cfg.min_freq);
        mx   = longint'(gov_cfg.max_freq);
        span = (mx > mn) ? mx - mn : 0;
        goal = longint'(goal_state);
        temp = longint'($signed(t.temp));
        run  = longint'(t.run);
        step = longint'(gov_cfg.decay_step);

        // utilization: report if present, else derived from the die temperature
        if (t.has)
        begin
            util = longint'(t.rep);
            if (t.rep > gov_cfg.busy_pct)
                busy_stamp = t.now;
        end
        else
            util = (temp - 320) / 20;   // truncates toward zero
        if (util < 0)
            util = 0;
        if (util > 100)
            util = 100;

        target = mn + span * util / 100;
        if (target > mx)
            target = mx;
        if (target < mn)
            target = mn;

        // hysteresis against the goal's own percentage, which may leave 0..100
        pct  = (span > 0) ? (goal - mn) * 100 / span : 0;
        diff = util - pct;
        if (diff < 0)
            diff = -diff;
        if (target != goal && diff > 5)
            goal = target;

        // idle decay; time differences wrap modulo 2^64
        since_busy  = t.now - busy_stamp;
        since_decay = t.now - decay_stamp;
        if (!t.has && util < 20 && temp < 480 && goal > mn &&
            since_busy > gov_cfg.quiet_time && since_decay >= gov_cfg.cooldown)
        begin
            goal = goal - step;
            if (goal < mn)
                goal = mn;
            decay_stamp = t.now;
        end

        goal_state = goal[FREQ_W-1:0];
        goal       = longint'(goal_state);

        v.goal = goal_state;
        v.util = util[UTIL_W-1:0];
        v.vreq = VREQ_NONE;
        if (goal > run)
        begin
            if (goal > longint'(gov_cfg.top_volt))
                v.vreq = VREQ_TOP;
            else if (goal > longint'(gov_cfg.mid_volt))
                v.vreq = VREQ_MID;
        end
        v.ramp = (goal != run);
        return v;
    endfunction

    function automatic tick_t make_tick(logic has, int rep, int temp, logic [TIME_W-1:0] now,
                                        int run);
        tick_t t;
        t.has  = has;
        t.rep  = rep[REP_W-1:0];
        t.temp = temp[TEMP_W-1:0];
        t.now  = now;
        t.run  = run[FREQ_W-1:0];
        return t;
    endfunction

    // Random tick: time mostly moves forward, with jumps and wraps now and then.
    function automatic tick_t draw_tick();
        tick_t t;
        int    pick;
        case ($urandom_range(0, 19))
            0:       sim_now_us = {$urandom, $urandom};
            1:       sim_now_us = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 200000);
            default: sim_now_us = sim_now_us + $urandom_range(0, 400000);
        endcase
        t.now = sim_now_us;
        t.has = ($urandom_range(0, 99) < report_share);

        pick = $urandom_range(0, 9);
        if (pick < 4)
            t.rep = REP_W'($urandom_range(0, 30));
        else if (pick < 7)
            t.rep = REP_W'($urandom_range(0, 100));
        else
            t.rep = REP_W'($urandom_range(0, 255));

        // cool die is what lets idle decay happen
        pick = $urandom_range(0, 9);
        if (pick < 4)
            t.temp = TEMP_W'($urandom_range(300, 479));
        else if (pick < 8)
            t.temp = TEMP_W'($urandom_range(0, 1650) - 400);
        else
            t.temp = TEMP_W'($urandom_range(0, 4095));

        pick = $urandom_range(0, 9);
        if (pick < 3)
            t.run = goal_state;
        else if (pick < 4)
            t.run = FREQ_W'($urandom_range(0, 19'h7FFFF));
        else
            t.run = FREQ_W'($urandom_range(0, 500000));
        return t;
    endfunction

    function automatic logic [QUIET_W-1:0] draw_interval();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return QUIET_W'($urandom_range(0, 300000));
            2:       return QUIET_W'($urandom_range(0, 3000000));
            default: return QUIET_W'($urandom_range(0, 100000000));
        endcase
    endfunction

    function automatic ufg_cfg_t draw_settings();
        ufg_cfg_t c;
        int       mn;
        mn = $urandom_range(0, 500000);
        c.min_freq = FREQ_W'(mn);
        // now and then an empty or inverted range
        if ($urandom_range(0, 9) == 0 || mn == 500000)
            c.max_freq = FREQ_W'($urandom_range(1, (mn > 0) ? mn : 1));
        else
            c.max_freq = FREQ_W'($urandom_range(mn + 1, 500000));
        c.busy_pct   = UTIL_W'($urandom_range(0, 100));
        c.quiet_time = draw_interval();
        c.cooldown   = draw_interval();
        c.decay_step = STEP_W'($urandom_range(0, 100000));
        c.top_volt   = FREQ_W'($urandom_range(0, 500000));
        c.mid_volt   = FREQ_W'($urandom_range(0, 500000));
        return c;
    endfunction

    // Offers one tick and returns at the edge where it is taken.
    task automatic send_tick(tick_t t);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_REP_LSB  +: REP_W]  = t.rep;
        word[IN_TEMP_LSB +: TEMP_W] = t.temp;
        word[IN_NOW_LSB  +: TIME_W] = t.now;
        word[IN_RUN_LSB  +: FREQ_W] = t.run;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.has;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tick_verdicts.push_back(govern_tick(t));
    endtask

    task automatic pause_sender(int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender stops until every owed result is in and the block has settled.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tick_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN_FREQ:   gov_cfg.min_freq   = val[FREQ_W-1:0];
            REG_MAX_FREQ:   gov_cfg.max_freq   = val[FREQ_W-1:0];
            REG_BUSY_PCT:   gov_cfg.busy_pct   = val[UTIL_W-1:0];
            REG_QUIET_TIME: gov_cfg.quiet_time = val[QUIET_W-1:0];
            REG_COOLDOWN:   gov_cfg.cooldown   = val[QUIET_W-1:0];
            REG_DECAY_STEP: gov_cfg.decay_step = val[STEP_W-1:0];
            REG_TOP_VOLT:   gov_cfg.top_volt   = val[FREQ_W-1:0];
            REG_MID_VOLT:   gov_cfg.mid_volt   = val[FREQ_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all eight registers, only once the block is idle.
    task automatic apply_settings(ufg_cfg_t c);
        drain_results();
        write_reg(REG_MIN_FREQ,   CFG_DATA_W'(c.min_freq));
        write_reg(REG_MAX_FREQ,   CFG_DATA_W'(c.max_freq));
        write_reg(REG_BUSY_PCT,   CFG_DATA_W'(c.busy_pct));
        write_reg(REG_QUIET_TIME, CFG_DATA_W'(c.quiet_time));
        write_reg(REG_COOLDOWN,   CFG_DATA_W'(c.cooldown));
        write_reg(REG_DECAY_STEP, CFG_DATA_W'(c.decay_step));
        write_reg(REG_TOP_VOLT,   CFG_DATA_W'(c.top_volt));
        write_reg(REG_MID_VOLT,   CFG_DATA_W'(c.mid_volt));
    endtask

    // Field extremes, report clamp, temperature path incl. truncation toward zero.
    task automatic test_field_extremes();
        send_tick(make_tick(1'b1, 0, 0, 64'd0, 0));
        send_tick(make_tick(1'b1, 255, -2048, 64'hFFFF_FFFF_FFFF_FFFF, 19'h7FFFF));
        send_tick(make_tick(1'b1, 100, 2047, 64'd1000, 500000));
        send_tick(make_tick(1'b1, 101, -1, 64'd2000, 0));
        send_tick(make_tick(1'b0, 0, -2048, 64'd3000, 125000));
        send_tick(make_tick(1'b0, 255, 2047, 64'd4000, 0));
        send_tick(make_tick(1'b0, 0, 319, 64'd5000, 0));
        send_tick(make_tick(1'b0, 0, 340, 64'd6000, 0));
    endtask

    // 50% goal, then 4 and 6 points off, then exactly 5 points off.
    task automatic test_hysteresis();
        send_tick(make_tick(1'b1, 50, 0, 64'd7000, 0));
        send_tick(make_tick(1'b1, 54, 0, 64'd8000, 0));
        send_tick(make_tick(1'b1, 56, 0, 64'd9000, 0));
        send_tick(make_tick(1'b1, 51, 0, 64'd9500, 0));
    endtask

    // Top, mid and no pre-raise; last one with goal below the running clock.
    task automatic test_voltage_request();
        send_tick(make_tick(1'b1, 100, 0, 64'd10_000_000, 0));
        send_tick(make_tick(1'b1, 60, 0, 64'd10_060_000, 0));
        send_tick(make_tick(1'b1, 10, 0, 64'd10_120_000, 500000));
    endtask

    // Quiet time, cooldown, a decay that is not clamped and a time stamp wrap.
    task automatic test_idle_decay();
        ufg_cfg_t c;
        c = CFG_RESET;
        c.quiet_time = 27'd1000;
        c.cooldown   = 27'd500;
        c.decay_step = 17'd3000;
        apply_settings(c);
        send_tick(make_tick(1'b1, 90, 0, 64'd20_000_000, 0));
        send_tick(make_tick(1'b0, 0, 400, 64'd20_000_500, 0));
        send_tick(make_tick(1'b0, 0, 400, 64'd20_002_000, 0));
        send_tick(make_tick(1'b1, 30, 0, 64'd20_002_100, 0));
        send_tick(make_tick(1'b0, 0, 400, 64'd20_002_300, 0));
        send_tick(make_tick(1'b0, 0, 400, 64'd10, 0));
    endtask

    // Inverted and empty ranges, goal below min and above max after a write.
    task automatic test_range_corners();
        ufg_cfg_t c;
        c = CFG_RESET;
        c.min_freq = 19'd300000;        // above max: target is pinned to min
        apply_settings(c);
        send_tick(make_tick(1'b1, 0, 0, 64'd30_000_000, 0));
        send_tick(make_tick(1'b1, 100, 0, 64'd30_060_000, 0));
        c.min_freq = 19'd0;
        c.max_freq = 19'd100000;        // goal now far above 100 percent
        apply_settings(c);
        send_tick(make_tick(1'b1, 100, 0, 64'd30_120_000, 0));
        c.min_freq = 19'd200000;
        c.max_freq = 19'd200000;
        apply_settings(c);
        send_tick(make_tick(1'b1, 50, 0, 64'd30_180_000, 0));
    endtask

    // Receiver holds off long while ticks keep coming, so s_axis_tready drops.
    task automatic test_back_pressure();
        apply_settings(CFG_RESET);
        rx_mode      = RX_OPEN;
        hold_request = 1000;
        for (int k = 0; k < 6; k++)
            send_tick(draw_tick());
        drain_results();
        rx_mode = RX_CHOPPY;
    endtask

    // Phases of random ticks under fixed, extreme and random settings.
    task automatic test_random_traffic();
        ufg_cfg_t c;
        int       count;
        int       burst;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: c = CFG_RESET;
                1:
                begin
                    c = '{min_freq: 19'd0, max_freq: 19'd500000, busy_pct: 7'd100,
                          quiet_time: 27'd0, cooldown: 27'd0, decay_step: 17'd100000,
                          top_volt: 19'd500000, mid_volt: 19'd0};
                end
                2:
                begin
                    c = '{min_freq: 19'd500000, max_freq: 19'd1, busy_pct: 7'd0,
                          quiet_time: 27'd100000000, cooldown: 27'd100000000,
                          decay_step: 17'd0, top_volt: 19'd0, mid_volt: 19'd500000};
                end
                default: c = draw_settings();
            endcase
            apply_settings(c);
            rx_mode      = phase[0] ? RX_OPEN : RX_CHOPPY;
            report_share = (phase == 1 || phase == 4) ? 15 : 50;
            count = 0;
            while (count < 150)
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && count < 150; k++)
                begin
                    send_tick(draw_tick());
                    count++;
                end
                // phase 3 runs back to back on an open receiver
                if (phase != 3)
                    pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120));
            end
        end
    endtask

    // Receiver: long hold-off when asked, else open or a random stall pattern.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_mode == RX_OPEN)
            m_axis_tready <= 1'b1;
        else
        begin
            if (rx_run == 0)
            begin
                rx_open = ($urandom_range(0, 2) != 0);
                rx_run  = rx_open ? $urandom_range(1, 10) : $urandom_range(1, 25);
            end
            rx_run--;
            m_axis_tready <= rx_open;
        end
    end

    // Result check: every accepted word against the oldest owed verdict.
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.goal = m_axis_tdata[OUT_GOAL_LSB +: FREQ_W];
            got.util = m_axis_tdata[OUT_UTIL_LSB +: UTIL_W];
            got.vreq = m_axis_tdata[OUT_VREQ_LSB +: VREQ_W];
            got.ramp = m_axis_tdata[OUT_RAMP_LSB];
            if (tick_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected word goal %0d util %0d vreq %0d ramp %0d",
                             $realtime, got.goal, got.util, got.vreq, got.ramp);
            end
            else
            begin
                want = tick_verdicts.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: word mismatch goal %0d/%0d util %0d/%0d ",
                                  "vreq %0d/%0d ramp %0d/%0d (expected/actual)"},
                                 $realtime, want.goal, got.goal, want.util, got.util,
                                 want.vreq, got.vreq, want.ramp, got.ramp);
                end
            end
        end
    end

    // Run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_utilization_frequency_governor failed");
        $finish;
    end

    initial
    begin
        gov_cfg     = CFG_RESET;
        goal_state  = CFG_RESET.min_freq;
        busy_stamp  = '0;
        decay_stamp = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_hysteresis();
        test_voltage_request();
        test_idle_decay();
        test_range_corners();
        test_back_pressure();
        test_random_traffic();

        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && tick_verdicts.size() == 0)
            $display("tb_utilization_frequency_governor passed");
        else
            $display("tb_utilization_frequency_governor failed");
        $finish;
    end

endmodule

@@ utilization_frequency_governor.f @@
+incdir+src
src/ufg_pkg.sv
src/ufg_div.sv
src/ufg_cfg.sv
src/utilization_frequency_governor.sv
src/ufg_checker.sv
verif/tb_utilization_frequency_governor.sv
